// ===== hw/rtl/dpat_pkg.sv =====
// ----------------------------------------------------------------------------
// dpat_pkg
// Shared sizes, state codes and page table port types of the translator.
// ----------------------------------------------------------------------------
package dpat_pkg;

   localparam int PAGE_BYTES   = 256;
   localparam int MEMORY_BYTES = 65536;

   localparam int VADDR_W      = 16;
   localparam int VSPACE_BYTES = 1 << VADDR_W;
   localparam int OFFSET_W     = $clog2(PAGE_BYTES);
   localparam int PAGE_W       = VADDR_W - OFFSET_W;
   localparam int PAGE_COUNT   = VSPACE_BYTES / PAGE_BYTES;
   localparam int FRAME_COUNT  = MEMORY_BYTES / PAGE_BYTES;
   localparam int FRAME_W      = $clog2(FRAME_COUNT);
   localparam int PHYS_W       = FRAME_W + OFFSET_W;
   localparam int BYTE_W       = 8;

   localparam logic ACT_TRANSLATE = 1'b0;
   localparam logic ACT_LOAD      = 1'b1;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_LOOKUP = 6'b000010,
      ST_COPY   = 6'b000100,
      ST_DRAIN  = 6'b001000,
      ST_FETCH  = 6'b010000,
      ST_READ   = 6'b100000
   } state_type;

   // lookup or allocate on one page table entry
   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [PAGE_W-1:0] page;
   } ptab_req_type;

   // registered lookup result
   typedef struct packed {
      logic               valid;
      logic [FRAME_W-1:0] frame;
   } ptab_rsp_type;

endpackage

// ===== hw/rtl/dpat_ptab.sv =====
// ----------------------------------------------------------------------------
// dpat_ptab
// Page table: valid bits in flops, frame numbers in a synchronous RAM,
// and the in-order frame allocator.
// ----------------------------------------------------------------------------
module dpat_ptab (
   input  logic                           clock,
   input  logic                           reset,
   input  dpat_pkg::ptab_req_type         req,
   output dpat_pkg::ptab_rsp_type         rsp,
   output logic [dpat_pkg::FRAME_W-1:0]   next_frame
);
   import dpat_pkg::*;

   logic [PAGE_COUNT-1:0] valid_ff;
   logic [PAGE_COUNT-1:0] valid_in;
   logic [FRAME_W-1:0]    next_ff;
   logic [FRAME_W-1:0]    next_in;
   logic [FRAME_W-1:0]    frame_mem [PAGE_COUNT];
   ptab_rsp_type          rsp_ff;

   always_comb begin
      valid_in = valid_ff;
      next_in  = next_ff;
      if (req.wr_en) begin
         valid_in[req.page] = 1'b1;
         next_in            = next_ff + 1'b1;   // wraps over the frame count
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         next_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         next_ff  <= next_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         frame_mem[req.page] <= next_ff;
      end
      if (req.rd_en) begin
         rsp_ff.frame <= frame_mem[req.page];
         rsp_ff.valid <= valid_ff[req.page];
      end
   end

   assign rsp        = rsp_ff;
   assign next_frame = next_ff;

endmodule

// ===== hw/rtl/demand_paged_address_translator.sv =====
// ----------------------------------------------------------------------------
// demand_paged_address_translator
// Demand-paged virtual to physical translation with a backing store.
// ----------------------------------------------------------------------------
// A load request writes one byte to the backing store and gives no response.
// A translate request looks its page up in the page table (one RAM read),
// then reads physical memory (one RAM read); on a hit the response register
// is loaded in the same cycle that the next request is taken. A miss
// allocates the next frame and copies the page from backing store to
// physical memory one byte a cycle through the single read port of the
// backing store. The response sits in an output register, so a stalled
// consumer holds only the result; the next request is still taken and
// worked on until its own result is due.
// No clearing pass is needed after reset: page table valid bits are flops.
// ----------------------------------------------------------------------------
module demand_paged_address_translator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_action,
   input  logic [dpat_pkg::VADDR_W-1:0]   req_address,
   input  logic [dpat_pkg::BYTE_W-1:0]    req_load_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [dpat_pkg::VADDR_W-1:0]   rsp_virt_addr,
   output logic [dpat_pkg::VADDR_W-1:0]   rsp_phys_addr,
   output logic signed [dpat_pkg::BYTE_W-1:0] rsp_value,
   output logic                           rsp_page_fault
);
   import dpat_pkg::*;

   localparam logic [OFFSET_W-1:0] OFFSET_LAST = OFFSET_W'(PAGE_BYTES - 1);

   // control state
   state_type            state_ff,    state_in;
   logic [VADDR_W-1:0]   addr_ff,     addr_in;
   logic [FRAME_W-1:0]   frame_ff,    frame_in;
   logic                 fault_ff,    fault_in;
   logic [OFFSET_W-1:0]  copy_cnt_ff, copy_cnt_in;
   logic                 copy_wr_ff,  copy_wr_in;
   logic [OFFSET_W-1:0]  copy_wa_ff,  copy_wa_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VADDR_W-1:0]   rsp_vaddr_ff, rsp_vaddr_in;
   logic [VADDR_W-1:0]   rsp_paddr_ff, rsp_paddr_in;
   logic [BYTE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic                 rsp_fault_ff, rsp_fault_in;

   // memories
   logic [BYTE_W-1:0]    bs_mem [VSPACE_BYTES];
   logic [BYTE_W-1:0]    pm_mem [MEMORY_BYTES];
   logic [BYTE_W-1:0]    bs_rdata_ff;
   logic [BYTE_W-1:0]    pm_rdata_ff;
   logic                 bs_rd_en;
   logic [VADDR_W-1:0]   bs_rd_addr;
   logic                 pm_rd_en;
   logic [PHYS_W-1:0]    pm_rd_addr;
   logic                 pm_wr_en;
   logic [PHYS_W-1:0]    pm_wr_addr;

   ptab_req_type         ptab_req;
   ptab_rsp_type         ptab_rsp;
   logic [FRAME_W-1:0]   ptab_next_frame;

   logic                 out_free;
   logic                 accept;
   logic [PAGE_W-1:0]    cur_page;
   logic [OFFSET_W-1:0]  cur_offset;
   logic [PHYS_W-1:0]    cur_phys;

   dpat_ptab u_ptab (
      .clock      (clock),
      .reset      (reset),
      .req        (ptab_req),
      .rsp        (ptab_rsp),
      .next_frame (ptab_next_frame)
   );

   assign cur_page   = addr_ff[VADDR_W-1:OFFSET_W];
   assign cur_offset = addr_ff[OFFSET_W-1:0];
   assign cur_phys   = {frame_ff, cur_offset};

   assign out_free  = !rsp_valid_ff || rsp_ready;
   // READ hands its result over and takes the next request in the same cycle
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_READ) && out_free);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      frame_in     = frame_ff;
      fault_in     = fault_ff;
      copy_cnt_in  = copy_cnt_ff;
      copy_wr_in   = copy_wr_ff;
      copy_wa_in   = copy_wa_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_vaddr_in = rsp_vaddr_ff;
      rsp_paddr_in = rsp_paddr_ff;
      rsp_value_in = rsp_value_ff;
      rsp_fault_in = rsp_fault_ff;

      bs_rd_en     = 1'b0;
      bs_rd_addr   = {cur_page, copy_cnt_ff};
      pm_rd_en     = 1'b0;
      pm_rd_addr   = cur_phys;
      pm_wr_en     = 1'b0;
      pm_wr_addr   = {frame_ff, copy_wa_ff};

      ptab_req.rd_en = 1'b0;
      ptab_req.wr_en = 1'b0;
      ptab_req.page  = cur_page;

      case (state_ff)
         ST_IDLE: begin
         end
         ST_LOOKUP: begin
            if (ptab_rsp.valid) begin
               frame_in   = ptab_rsp.frame;
               pm_rd_en   = 1'b1;
               pm_rd_addr = {ptab_rsp.frame, cur_offset};
               state_in   = ST_READ;
            end else begin
               // miss: claim the next frame and start the page copy
               ptab_req.wr_en = 1'b1;
               frame_in       = ptab_next_frame;
               fault_in       = 1'b1;
               copy_cnt_in    = '0;
               copy_wr_in     = 1'b0;
               state_in       = ST_COPY;
            end
         end
         ST_COPY: begin
            // read byte n from backing store, write byte n-1 to its frame
            bs_rd_en    = 1'b1;
            pm_wr_en    = copy_wr_ff;
            copy_wr_in  = 1'b1;
            copy_wa_in  = copy_cnt_ff;
            copy_cnt_in = copy_cnt_ff + 1'b1;
            if (copy_cnt_ff == OFFSET_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            pm_wr_en   = 1'b1;
            copy_wr_in = 1'b0;
            state_in   = ST_FETCH;
         end
         ST_FETCH: begin
            pm_rd_en = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_vaddr_in = addr_ff;
               rsp_paddr_in = VADDR_W'(cur_phys);
               rsp_value_in = pm_rdata_ff;
               rsp_fault_in = fault_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (accept) begin
         if (req_action == ACT_TRANSLATE) begin
            ptab_req.rd_en = 1'b1;
            ptab_req.page  = req_address[VADDR_W-1:OFFSET_W];
            addr_in        = req_address;
            fault_in       = 1'b0;
            state_in       = ST_LOOKUP;
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         copy_wr_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         copy_wr_ff   <= copy_wr_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      frame_ff     <= frame_in;
      fault_ff     <= fault_in;
      copy_cnt_ff  <= copy_cnt_in;
      copy_wa_ff   <= copy_wa_in;
      rsp_vaddr_ff <= rsp_vaddr_in;
      rsp_paddr_ff <= rsp_paddr_in;
      rsp_value_ff <= rsp_value_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   // backing store: written by load requests, read by the page copy
   always_ff @(posedge clock) begin
      if (accept && (req_action == ACT_LOAD)) begin
         bs_mem[req_address] <= req_load_byte;
      end
      if (bs_rd_en) begin
         bs_rdata_ff <= bs_mem[bs_rd_addr];
      end
   end

   // physical memory: written by the page copy, read for the response
   always_ff @(posedge clock) begin
      if (pm_wr_en) begin
         pm_mem[pm_wr_addr] <= bs_rdata_ff;
      end
      if (pm_rd_en) begin
         pm_rdata_ff <= pm_mem[pm_rd_addr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_virt_addr  = rsp_vaddr_ff;
   assign rsp_phys_addr  = rsp_paddr_ff;
   assign rsp_value      = signed'(rsp_value_ff);
   assign rsp_page_fault = rsp_fault_ff;

endmodule

// ===== tb/demand_paged_address_translator_tb.sv =====
// ----------------------------------------------------------------------------
// demand_paged_address_translator_tb
// Self-checking bench for the demand-paged translator: backing store pages are
// filled by load requests before any translation touches them, translations
// are predicted by a behavioural page table and memory image, and every
// response is compared field by field in arrival order.
// ----------------------------------------------------------------------------

// Behavioural copy of the translator: page table, physical memory image and
// backing store image, plus the queue of translations still awaited.
class page_translation_model;

   typedef struct {
      logic [dpat_pkg::VADDR_W-1:0]       virt_addr;
      logic [dpat_pkg::VADDR_W-1:0]       phys_addr;
      logic signed [dpat_pkg::BYTE_W-1:0] value;
      logic                               page_fault;
   } translation_type;

   bit [dpat_pkg::BYTE_W-1:0]  backing_image [dpat_pkg::VSPACE_BYTES];
   bit [dpat_pkg::BYTE_W-1:0]  frame_image [dpat_pkg::MEMORY_BYTES];
   bit                         entry_valid [dpat_pkg::PAGE_COUNT];
   bit [dpat_pkg::FRAME_W-1:0] entry_frame [dpat_pkg::PAGE_COUNT];
   int unsigned                next_frame;
   translation_type            awaited_translations [$];
   int unsigned                mismatches;

   function new();
      next_frame  = 0;
      mismatches  = 0;
   endfunction

   function int unsigned pending();
      return awaited_translations.size();
   endfunction

   // accepted request: loads update the backing image, translations queue
   // the expected response
   function void note_request(logic action, logic [dpat_pkg::VADDR_W-1:0] address,
                              logic [dpat_pkg::BYTE_W-1:0] load_byte);
      int unsigned     page;
      int unsigned     offset;
      int unsigned     frame;
      int unsigned     phys;
      bit              fault;
      translation_type t;
      if (action == dpat_pkg::ACT_LOAD) begin
         backing_image[address] = load_byte;
         return;
      end
      page   = address / dpat_pkg::PAGE_BYTES;
      offset = address % dpat_pkg::PAGE_BYTES;
      fault  = 1'b0;
      if (!entry_valid[page]) begin
         fault = 1'b1;
         frame = next_frame % dpat_pkg::FRAME_COUNT;
         for (int i = 0; i < dpat_pkg::PAGE_BYTES; i++) begin
            frame_image[frame * dpat_pkg::PAGE_BYTES + i] =
               backing_image[page * dpat_pkg::PAGE_BYTES + i];
         end
         entry_valid[page] = 1'b1;
         entry_frame[page] = frame[dpat_pkg::FRAME_W-1:0];
         next_frame        = (frame + 1) % dpat_pkg::FRAME_COUNT;
      end
      phys = entry_frame[page] * dpat_pkg::PAGE_BYTES + offset;
      t.virt_addr  = address;
      t.phys_addr  = phys[dpat_pkg::VADDR_W-1:0];
      t.value      = frame_image[phys % dpat_pkg::MEMORY_BYTES];
      t.page_fault = fault;
      awaited_translations.push_back(t);
   endfunction

   task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
   endtask

   task check_translation(logic [dpat_pkg::VADDR_W-1:0] virt_addr,
                          logic [dpat_pkg::VADDR_W-1:0] phys_addr,
                          logic signed [dpat_pkg::BYTE_W-1:0] value,
                          logic page_fault);
      translation_type t;
      if (awaited_translations.size() == 0) begin
         report_mismatch($sformatf("response va=%h with no translation outstanding",
                                   virt_addr));
         return;
      end
      t = awaited_translations.pop_front();
      if (virt_addr !== t.virt_addr)
         report_mismatch($sformatf("virt_addr %h, expected %h",
                                   virt_addr, t.virt_addr));
      if (phys_addr !== t.phys_addr)
         report_mismatch($sformatf("va %h: phys_addr %h, expected %h",
                                   t.virt_addr, phys_addr, t.phys_addr));
      if (value !== t.value)
         report_mismatch($sformatf("va %h: value %0d, expected %0d",
                                   t.virt_addr, value, t.value));
      if (page_fault !== t.page_fault)
         report_mismatch($sformatf("va %h: page_fault %b, expected %b",
                                   t.virt_addr, page_fault, t.page_fault));
   endtask

endclass

module demand_paged_address_translator_tb;

   import dpat_pkg::*;

   // the limit is several times the worst case of about 1350 requests, each
   // at most a page copy plus stalls and gaps
   localparam int CYCLE_LIMIT = 2000000;
   localparam int TOTAL_ITEMS = 1350;
   localparam int QUIET_ITEMS = 200;   // closing stretch with no idling
   localparam int MAX_FILLED  = 4;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_action;
   logic [VADDR_W-1:0]        req_address;
   logic [BYTE_W-1:0]         req_load_byte;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [VADDR_W-1:0]        rsp_virt_addr;
   logic [VADDR_W-1:0]        rsp_phys_addr;
   logic signed [BYTE_W-1:0]  rsp_value;
   logic                      rsp_page_fault;

   page_translation_model     translations;

   // stimulus bookkeeping: a page may only be translated once every byte of
   // it has been loaded (or once it is already resident)
   bit                        filled [PAGE_COUNT];
   int unsigned               filled_pages [$];
   bit                        idle_on;
   bit                        cut_in_on;
   bit                        mid_drained;
   int unsigned               sent_items;
   int unsigned               stall_left = 0;
   int unsigned               cycle_count = 0;

   demand_paged_address_translator i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_address    (req_address),
      .req_load_byte  (req_load_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_virt_addr  (rsp_virt_addr),
      .rsp_phys_addr  (rsp_phys_addr),
      .rsp_value      (rsp_value),
      .rsp_page_fault (rsp_page_fault)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Everything the block sees is sampled here at the rising edge; the bench
   // only changes inputs on the falling edge, so there is no race.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         translations.note_request(req_action, req_address, req_load_byte);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         translations.check_translation(rsp_virt_addr, rsp_phys_addr,
                                        rsp_value, rsp_page_fault);
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Response side back-pressure: stall bursts of random length start
   // only while idling is switched on.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_ready  <= 1'b1;
      end
   end

   // Present one request and hold it until it is taken. Entered and left on a
   // falling edge. A gap lowers valid first and waits for a falling edge before
   // raising it again, so valid never gets two assignments in one time step.
   task automatic send_request(input logic action, input logic [VADDR_W-1:0] address,
                               input logic [BYTE_W-1:0] load_byte);
      int unsigned gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= action;
      req_address   <= address;
      req_load_byte <= load_byte;
      do @(posedge clock); while (!req_ready);
      sent_items++;
      @(negedge clock);
   endtask

   // Sender holds off until every outstanding translation has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (translations.pending() != 0);
   endtask

   // Translate a random byte of a page whose backing copy is complete; the
   // load byte is random as the block must ignore it.
   task automatic translate_random();
      int unsigned        page;
      logic [VADDR_W-1:0] address;
      page    = filled_pages[$urandom_range(0, filled_pages.size() - 1)];
      address = VADDR_W'(page * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1));
      send_request(ACT_TRANSLATE, address, BYTE_W'($urandom_range(0, 255)));
   endtask

   // Load 'count' bytes of a page, picked in shuffled order, with random
   // content. Occasionally a translation of another page cuts in. Only a
   // complete fill makes the page eligible for translation.
   task automatic fill_page(input int unsigned page, input int unsigned count);
      int unsigned        order [PAGE_BYTES];
      int unsigned        j;
      int unsigned        tmp;
      logic [VADDR_W-1:0] address;
      for (int i = 0; i < PAGE_BYTES; i++) order[i] = i;
      for (int i = PAGE_BYTES - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (int i = 0; i < count; i++) begin
         address = VADDR_W'(page * PAGE_BYTES + order[i]);
         send_request(ACT_LOAD, address, BYTE_W'($urandom_range(0, 255)));
         if (cut_in_on && filled_pages.size() > 0 && $urandom_range(0, 31) == 0)
            translate_random();
      end
      if (count == PAGE_BYTES && !filled[page]) begin
         filled[page] = 1'b1;
         filled_pages.push_back(page);
      end
   endtask

   function automatic int unsigned fresh_page();
      int unsigned page;
      page = $urandom_range(0, PAGE_COUNT - 1);
      while (filled[page]) page = $urandom_range(0, PAGE_COUNT - 1);
      return page;
   endfunction

   initial begin
      int unsigned pick;
      translations  = new();
      idle_on       = 1'b1;
      cut_in_on     = 1'b0;
      mid_drained   = 1'b0;
      sent_items    = 0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_action    <= ACT_TRANSLATE;
      req_address   <= '0;
      req_load_byte <= '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // --- directed: lowest and highest pages, value extremes, hits, faults
      fill_page(0, PAGE_BYTES);
      fill_page(PAGE_COUNT - 1, PAGE_BYTES);
      send_request(ACT_LOAD, 16'h0000, 8'h80);       // most negative value
      send_request(ACT_LOAD, 16'h00FF, 8'h7F);       // most positive value
      send_request(ACT_LOAD, 16'h0001, 8'h00);
      send_request(ACT_LOAD, 16'h0002, 8'hFF);
      send_request(ACT_TRANSLATE, 16'h0000, 8'hFF);  // miss, frame 0
      send_request(ACT_TRANSLATE, 16'h00FF, 8'h00);  // hit, last offset
      send_request(ACT_TRANSLATE, 16'h0001, 8'h55);
      send_request(ACT_TRANSLATE, 16'h0002, 8'hAA);
      send_request(ACT_TRANSLATE, 16'hFFFF, 8'h00);  // miss on top page
      send_request(ACT_TRANSLATE, 16'hFF00, 8'hFF);  // hit on top page
      // load after translation: resident copy must keep the old byte
      send_request(ACT_LOAD, 16'h0010, 8'h5A);
      send_request(ACT_LOAD, 16'hFF80, 8'hA5);
      send_request(ACT_TRANSLATE, 16'h0010, 8'h00);
      send_request(ACT_TRANSLATE, 16'hFF80, 8'h00);
      send_request(ACT_TRANSLATE, 16'h00AA, 8'h00);  // successive hits
      send_request(ACT_TRANSLATE, 16'hFF55, 8'h00);
      send_request(ACT_TRANSLATE, 16'h0000, 8'h00);
      wait_for_drain();

      // --- random: mostly translations of loaded pages, with whole-page
      // fills, short abandoned partial fills and stray loads anywhere
      cut_in_on = 1'b1;
      for (int n = 0; sent_items < TOTAL_ITEMS; n++) begin
         if (sent_items >= TOTAL_ITEMS - QUIET_ITEMS) idle_on = 1'b0;
         else if (n % 150 == 0) idle_on = ($urandom_range(0, 3) != 0);
         if (!mid_drained && sent_items >= TOTAL_ITEMS / 2) begin
            wait_for_drain();
            mid_drained = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 3 && filled_pages.size() < MAX_FILLED &&
             sent_items + PAGE_BYTES < TOTAL_ITEMS - QUIET_ITEMS) begin
            fill_page(fresh_page(), PAGE_BYTES);
         end else if (pick < 4) begin
            fill_page(fresh_page(), $urandom_range(1, 15));
         end else if (pick < 14) begin
            send_request(ACT_LOAD, VADDR_W'($urandom_range(0, 65535)),
                         BYTE_W'($urandom_range(0, 255)));
         end else begin
            translate_random();
         end
      end

      // --- drain, then allow for a page copy still in flight
      req_valid <= 1'b0;
      do @(negedge clock); while (translations.pending() != 0);
      repeat (PAGE_BYTES + 16) @(negedge clock);
      if (translations.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
